### rtl/lcsp_pkg.sv
// Package for the LED color sequence player: payload structs, op and status
// codes, size constants. No dependencies.
package lcsp_pkg;

   localparam int MAX_ROWS_DEF    = 16;
   localparam int STORE_BYTES_DEF = 384;
   localparam int BYTES_PER_ROW   = 24;
   localparam int ROW_CNT_W       = 5;
   localparam int RECIP3          = 171;  // floor(x*171/512) == x/3 for x < 384

   localparam logic [ROW_CNT_W-1:0] ROW_COUNT_RST = ROW_CNT_W'(16);

   localparam logic [2:0] OP_TICK   = 3'd0;
   localparam logic [2:0] OP_WRITE  = 3'd1;
   localparam logic [2:0] OP_COMMIT = 3'd2;
   localparam logic [2:0] OP_START  = 3'd3;
   localparam logic [2:0] OP_STOP   = 3'd4;
   localparam logic [2:0] OP_RESET  = 3'd5;
   localparam logic [2:0] OP_BEAT   = 3'd6;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BAD_ARG   = 2'd1;
   localparam logic [1:0] ST_BAD_STATE = 2'd2;

   typedef struct packed {
      logic [2:0] op;
      logic [8:0] byte_index;
      logic [7:0] byte_value;
      logic [7:0] rhythm;
      logic [7:0] rows;
      logic [7:0] beat_position;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic       led_update;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       playing;
   } rsp_type;

   // one byte write into the store, split into word and byte lane
   typedef struct packed {
      logic       en;
      logic [6:0] addr;
      logic [1:0] lane;
      logic [7:0] data;
   } store_wr_type;

endpackage

### rtl/lcsp_store.sv
// Pattern store: three byte lanes of packed color words, one word per square
// pair, with a zeroing sweep after reset. Uses lcsp_pkg.
module lcsp_store #(
   parameter int WORDS = 128,
   parameter int AW    = 7
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lcsp_pkg::store_wr_type wr,
   input  logic                  rd_en,
   input  logic [AW-1:0]         rd_addr,
   output logic [23:0]           rd_data,
   output logic                  busy
);

   logic          clearing_ff, clearing_in;
   logic [AW-1:0] clr_ptr_ff, clr_ptr_in;
   logic [AW-1:0] waddr;
   logic [7:0]    wdata;

   always_comb begin
      clearing_in = clearing_ff;
      clr_ptr_in  = clr_ptr_ff;
      if (clearing_ff) begin
         clr_ptr_in = clr_ptr_ff + AW'(1);
         if (clr_ptr_ff == AW'(WORDS - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_ptr_ff  <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_ptr_ff  <= clr_ptr_in;
      end
   end

   assign waddr = clearing_ff ? clr_ptr_ff : wr.addr[AW-1:0];
   assign wdata = clearing_ff ? 8'h00 : wr.data;
   assign busy  = clearing_ff;

   for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [7:0] mem_ff [WORDS];
      logic [7:0] q_ff;
      logic       we;

      assign we = clearing_ff || (wr.en && wr.lane == 2'(l));

      always_ff @(posedge clock) begin
         if (we) begin
            mem_ff[waddr] <= wdata;
         end
         if (rd_en) begin
            q_ff <= mem_ff[rd_addr];
         end
      end

      assign rd_data[23-8*l -: 8] = q_ff;
   end

endmodule

### rtl/led_color_sequence_player.sv
// Top level of the LED color sequence player: command decode, playback
// state and result register. Uses lcsp_pkg and lcsp_store.
//
// One item is taken per cycle while req_ready is high; its result comes
// through the command register, then the pattern store read, and items stream
// back to back while rsp_ready stays high. After reset the pattern store is
// zeroed one word per cycle, ceil(STORE_BYTES/3) words (128 by default),
// during which req_ready stays low. Colors are 12-bit, two squares per
// three bytes, 16 squares per row; each nibble is returned times 16.
module led_color_sequence_player #(
   parameter int MAX_ROWS    = lcsp_pkg::MAX_ROWS_DEF,
   parameter int STORE_BYTES = lcsp_pkg::STORE_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lcsp_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lcsp_pkg::rsp_type rsp_data
);

   localparam int WORDS     = (STORE_BYTES + 2) / 3;
   localparam int AW        = $clog2(WORDS);
   localparam int ROW_FIT   = STORE_BYTES / lcsp_pkg::BYTES_PER_ROW;
   localparam int ROW_LIMIT = (MAX_ROWS < ROW_FIT) ? MAX_ROWS : ROW_FIT;
   localparam int RCW       = lcsp_pkg::ROW_CNT_W;

   // command stage
   logic              s1_valid_ff;
   lcsp_pkg::req_type s1_item_ff;
   // result stage
   logic              s2_valid_ff;
   logic [1:0]        s2_status_ff, s2_status_in;
   logic              s2_upd_ff, s2_upd_in;
   logic              s2_show_ff, s2_show_in;
   logic              s2_odd_ff;
   logic              s2_playing_ff;

   // playback state
   logic [7:0]     step_ticks_ff, step_ticks_in;
   logic [RCW-1:0] row_count_ff, row_count_in;
   logic [7:0]     position_ff, position_in;
   logic [7:0]     tick_count_ff, tick_count_in;
   logic           active_ff, active_in;

   logic        s2_free, s1_adv, store_busy;
   logic [8:0]  squares, pos_next, beat_pos;
   logic [16:0] idx_prod;
   logic [7:0]  word_q;
   logic [8:0]  lane_r;
   logic [23:0] rd_data;
   logic [3:0]  nib_r, nib_g, nib_b;
   lcsp_pkg::store_wr_type wr;

   assign s2_free   = !s2_valid_ff || rsp_ready;
   assign s1_adv    = s1_valid_ff && s2_free;
   assign req_ready = !store_busy && (!s1_valid_ff || s1_adv);

   assign squares  = {row_count_ff, 4'b0000};
   assign beat_pos = {1'b0, s1_item_ff.beat_position};
   assign pos_next = ({1'b0, position_ff} + 9'd1 >= squares)
                   ? {1'b0, position_ff} + 9'd1 - squares
                   : {1'b0, position_ff} + 9'd1;

   // byte address -> word (index / 3) and lane (index % 3)
   assign idx_prod = {8'b0, s1_item_ff.byte_index} * 17'(lcsp_pkg::RECIP3);
   assign word_q   = idx_prod[16:9];
   assign lane_r   = s1_item_ff.byte_index - ({1'b0, word_q} * 9'd3);

   always_comb begin
      wr      = '0;
      wr.addr = 7'(word_q);
      wr.lane = lane_r[1:0];
      wr.data = s1_item_ff.byte_value;
      wr.en   = s1_adv && s1_item_ff.op == lcsp_pkg::OP_WRITE
                && {1'b0, s1_item_ff.byte_index} < 10'(STORE_BYTES);
   end

   always_comb begin
      step_ticks_in = step_ticks_ff;
      row_count_in  = row_count_ff;
      position_in   = position_ff;
      tick_count_in = tick_count_ff;
      active_in     = active_ff;
      s2_status_in  = lcsp_pkg::ST_OK;
      s2_upd_in     = 1'b0;
      s2_show_in    = 1'b0;
      case (s1_item_ff.op)
         lcsp_pkg::OP_TICK: begin
            if (active_ff && step_ticks_ff != 8'd0) begin
               if ({1'b0, tick_count_ff} + 9'd1 >= {1'b0, step_ticks_ff}) begin
                  tick_count_in = 8'd0;
                  s2_upd_in     = 1'b1;
                  s2_show_in    = {1'b0, position_ff} < squares;
                  position_in   = pos_next[7:0];
               end else begin
                  tick_count_in = tick_count_ff + 8'd1;
               end
            end
         end
         lcsp_pkg::OP_WRITE: begin
            if ({1'b0, s1_item_ff.byte_index} >= 10'(STORE_BYTES)) begin
               s2_status_in = lcsp_pkg::ST_BAD_ARG;
            end
         end
         lcsp_pkg::OP_COMMIT: begin
            if (s1_item_ff.rhythm == 8'd0 || s1_item_ff.rows == 8'd0
                || s1_item_ff.rows > 8'(ROW_LIMIT)) begin
               s2_status_in = lcsp_pkg::ST_BAD_ARG;
            end else begin
               step_ticks_in = s1_item_ff.rhythm;
               row_count_in  = s1_item_ff.rows[RCW-1:0];
               position_in   = 8'd0;
               tick_count_in = 8'd0;
               active_in     = 1'b1;
            end
         end
         lcsp_pkg::OP_START: begin
            if (step_ticks_ff == 8'd0) begin
               s2_status_in = lcsp_pkg::ST_BAD_STATE;
            end else begin
               position_in   = 8'd0;
               tick_count_in = 8'd0;
               active_in     = 1'b1;
            end
         end
         lcsp_pkg::OP_STOP: begin
            active_in     = 1'b0;
            tick_count_in = 8'd0;
         end
         lcsp_pkg::OP_RESET: begin
            position_in = 8'd0;
            if (active_ff && step_ticks_ff != 8'd0) begin
               tick_count_in = 8'd0;
            end
         end
         lcsp_pkg::OP_BEAT: begin
            if (active_ff) begin
               if (beat_pos >= squares) begin
                  s2_status_in = lcsp_pkg::ST_BAD_ARG;
               end else begin
                  position_in   = s1_item_ff.beat_position;
                  tick_count_in = 8'd0;
               end
            end
         end
         default: begin
            s2_status_in = lcsp_pkg::ST_BAD_ARG;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         step_ticks_ff <= 8'd0;
         row_count_ff  <= lcsp_pkg::ROW_COUNT_RST;
         position_ff   <= 8'd0;
         tick_count_ff <= 8'd0;
         active_ff     <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
         if (s2_free) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s1_adv) begin
            step_ticks_ff <= step_ticks_in;
            row_count_ff  <= row_count_in;
            position_ff   <= position_in;
            tick_count_ff <= tick_count_in;
            active_ff     <= active_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_item_ff <= req_data;
      end
      if (s1_adv) begin
         s2_status_ff  <= s2_status_in;
         s2_upd_ff     <= s2_upd_in;
         s2_show_ff    <= s2_show_in;
         s2_odd_ff     <= position_ff[0];
         s2_playing_ff <= active_in;
      end
   end

   lcsp_store #(
      .WORDS (WORDS),
      .AW    (AW)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .rd_en   (s1_adv),
      .rd_addr (position_ff[AW:1]),
      .rd_data (rd_data),
      .busy    (store_busy)
   );

   // even square: byte0 hi, byte0 lo, byte1 hi; odd: byte1 lo, byte2 hi, byte2 lo
   assign nib_r = s2_odd_ff ? rd_data[11:8] : rd_data[23:20];
   assign nib_g = s2_odd_ff ? rd_data[7:4]  : rd_data[19:16];
   assign nib_b = s2_odd_ff ? rd_data[3:0]  : rd_data[15:12];

   always_comb begin
      rsp_data            = '0;
      rsp_data.status     = s2_status_ff;
      rsp_data.led_update = s2_upd_ff;
      rsp_data.playing    = s2_playing_ff;
      if (s2_upd_ff && s2_show_ff) begin
         rsp_data.red   = {nib_r, 4'b0000};
         rsp_data.green = {nib_g, 4'b0000};
         rsp_data.blue  = {nib_b, 4'b0000};
      end
   end

   assign rsp_valid = s2_valid_ff;

endmodule

### tb/sv/lcsp_playback_checker.sv
// Playback checker for the LED color sequence player: watches both channels,
// predicts each result from its own copy of the player state and compares.
// Depends on lcsp_pkg.
module lcsp_playback_checker #(
   parameter int MAX_ROWS    = lcsp_pkg::MAX_ROWS_DEF,
   parameter int STORE_BYTES = lcsp_pkg::STORE_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic              req_ready,
   input  lcsp_pkg::req_type req_data,
   input  logic              rsp_valid,
   input  logic              rsp_ready,
   input  lcsp_pkg::rsp_type rsp_data,
   output int                mismatches,
   output int                awaited
);

   logic [7:0]        pattern [STORE_BYTES];
   logic [7:0]        step_len;
   logic [4:0]        rows_loaded;
   logic [7:0]        sq_pos;
   logic [7:0]        tick_cnt;
   logic              playing_q;
   lcsp_pkg::rsp_type awaited_rsp [$];

   function automatic lcsp_pkg::rsp_type play_item(lcsp_pkg::req_type rq);
      lcsp_pkg::rsp_type rs;
      int                squares;
      int                base;
      logic [7:0]        b0, b1, b2;
      rs = '0;
      rs.status = lcsp_pkg::ST_OK;
      squares = int'(rows_loaded) * 16;
      case (rq.op)
         lcsp_pkg::OP_TICK: begin
            if (playing_q && step_len != 0) begin
               if (int'(tick_cnt) + 1 >= int'(step_len)) begin
                  tick_cnt = '0;
                  if (int'(sq_pos) < squares) begin
                     base = (int'(sq_pos) >> 1) * 3;
                     b0 = pattern[base];
                     b1 = pattern[base + 1];
                     b2 = pattern[base + 2];
                     if (!sq_pos[0]) begin
                        rs.red   = {b0[7:4], 4'h0};
                        rs.green = {b0[3:0], 4'h0};
                        rs.blue  = {b1[7:4], 4'h0};
                     end else begin
                        rs.red   = {b1[3:0], 4'h0};
                        rs.green = {b2[7:4], 4'h0};
                        rs.blue  = {b2[3:0], 4'h0};
                     end
                  end
                  rs.led_update = 1'b1;
                  sq_pos = (squares != 0) ? 8'((int'(sq_pos) + 1) % squares) : '0;
               end else begin
                  tick_cnt = tick_cnt + 8'd1;
               end
            end
         end
         lcsp_pkg::OP_WRITE: begin
            if (int'(rq.byte_index) < STORE_BYTES)
               pattern[rq.byte_index] = rq.byte_value;
            else
               rs.status = lcsp_pkg::ST_BAD_ARG;
         end
         lcsp_pkg::OP_COMMIT: begin
            if (rq.rhythm == 0 || rq.rows < 1 || int'(rq.rows) > MAX_ROWS ||
                int'(rq.rows) * lcsp_pkg::BYTES_PER_ROW > STORE_BYTES) begin
               rs.status = lcsp_pkg::ST_BAD_ARG;
            end else begin
               step_len = rq.rhythm;
               rows_loaded = rq.rows[4:0];
               sq_pos = '0;
               tick_cnt = '0;
               playing_q = 1'b1;
            end
         end
         lcsp_pkg::OP_START: begin
            if (step_len == 0) begin
               rs.status = lcsp_pkg::ST_BAD_STATE;
            end else begin
               sq_pos = '0;
               tick_cnt = '0;
               playing_q = 1'b1;
            end
         end
         lcsp_pkg::OP_STOP: begin
            playing_q = 1'b0;
            tick_cnt = '0;
         end
         lcsp_pkg::OP_RESET: begin
            sq_pos = '0;
            if (playing_q && step_len != 0)
               tick_cnt = '0;
         end
         lcsp_pkg::OP_BEAT: begin
            if (playing_q) begin
               if (int'(rq.beat_position) >= squares) begin
                  rs.status = lcsp_pkg::ST_BAD_ARG;
               end else begin
                  sq_pos = rq.beat_position;
                  tick_cnt = '0;
               end
            end
         end
         default: rs.status = lcsp_pkg::ST_BAD_ARG;
      endcase
      rs.playing = playing_q;
      return rs;
   endfunction

   task automatic compare_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
         $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      lcsp_pkg::rsp_type exp_rsp;
      if (reset) begin
         for (int i = 0; i < STORE_BYTES; i++)
            pattern[i] = '0;
         step_len = '0;
         rows_loaded = lcsp_pkg::ROW_COUNT_RST;
         sq_pos = '0;
         tick_cnt = '0;
         playing_q = 1'b0;
         awaited_rsp.delete();
      end else begin
         // older result leaves before the new transfer's prediction is queued
         if (rsp_valid && rsp_ready) begin
            if (awaited_rsp.size() == 0) begin
               $error("rsp transfer with no expected result");
               mismatches++;
            end else begin
               exp_rsp = awaited_rsp.pop_front();
               compare_field("status", exp_rsp.status, rsp_data.status);
               compare_field("led_update", exp_rsp.led_update, rsp_data.led_update);
               compare_field("red", exp_rsp.red, rsp_data.red);
               compare_field("green", exp_rsp.green, rsp_data.green);
               compare_field("blue", exp_rsp.blue, rsp_data.blue);
               compare_field("playing", exp_rsp.playing, rsp_data.playing);
            end
         end
         if (req_valid && req_ready)
            awaited_rsp.push_back(play_item(req_data));
      end
      awaited = awaited_rsp.size();
   end

endmodule

### tb/sv/led_color_sequence_player_tb.sv
// Testbench top for the LED color sequence player: clock, reset, stimulus
// and verdict. Depends on lcsp_pkg, led_color_sequence_player and
// lcsp_playback_checker.
module led_color_sequence_player_tb;

   localparam logic [2:0] OP_SPARE = 3'd7;
   localparam int RANDOM_ITEMS = 950;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int IDLE_PCT     = 38;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   lcsp_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   lcsp_pkg::rsp_type rsp_data;
   logic              req_fire = 1'b0;
   bit                steady = 1'b0;
   int                mismatches;
   int                awaited;
   int                cycle_count = 0;

   led_color_sequence_player dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   lcsp_playback_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data),
      .mismatches (mismatches),
      .awaited    (awaited)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      req_fire <= req_valid && req_ready;
   end

   always @(negedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
   end

   function automatic lcsp_pkg::req_type make_req(logic [2:0] op, logic [8:0] idx,
                                                  logic [7:0] val, logic [7:0] rhy,
                                                  logic [7:0] rws, logic [7:0] bpos);
      lcsp_pkg::req_type rq;
      rq.op = op;
      rq.byte_index = idx;
      rq.byte_value = val;
      rq.rhythm = rhy;
      rq.rows = rws;
      rq.beat_position = bpos;
      return rq;
   endfunction

   function automatic lcsp_pkg::req_type random_req();
      lcsp_pkg::req_type rq;
      logic [63:0]       raw;
      int                pick;
      raw = {$urandom, $urandom};
      rq = raw[43:0];
      pick = $urandom_range(99);
      if (pick < 45) begin
         rq.op = lcsp_pkg::OP_TICK;
      end else if (pick < 65) begin
         rq.op = lcsp_pkg::OP_WRITE;
         rq.byte_index = ($urandom_range(99) < 85) ? 9'($urandom_range(383))
                                                   : 9'($urandom_range(511));
      end else if (pick < 72) begin
         rq.op = lcsp_pkg::OP_COMMIT;
         pick = $urandom_range(99);
         rq.rhythm = (pick < 70) ? 8'($urandom_range(4, 1)) :
                     (pick < 90) ? 8'($urandom_range(255, 1)) : 8'd0;
         rq.rows = ($urandom_range(99) < 80) ? 8'($urandom_range(16, 1))
                                             : 8'($urandom_range(255));
      end else if (pick < 76) begin
         rq.op = lcsp_pkg::OP_START;
      end else if (pick < 79) begin
         rq.op = lcsp_pkg::OP_STOP;
      end else if (pick < 83) begin
         rq.op = lcsp_pkg::OP_RESET;
      end else if (pick < 96) begin
         rq.op = lcsp_pkg::OP_BEAT;
         rq.beat_position = ($urandom_range(1) == 0) ? 8'($urandom_range(31))
                                                     : 8'($urandom_range(255));
      end else begin
         rq.op = OP_SPARE;
      end
      return rq;
   endfunction

   // called at a falling edge; returns at the falling edge after the transfer
   task automatic send_item(lcsp_pkg::req_type rq);
      if (!steady) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            req_valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data <= rq;
      do @(negedge clock); while (!req_fire);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (awaited != 0);
   endtask

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      repeat (12) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // no sequence loaded yet
      send_item(make_req(lcsp_pkg::OP_TICK, 9'd0, 8'd0, 8'd0, 8'd0, 8'd0));
      send_item(make_req(lcsp_pkg::OP_START, 9'd0, 8'd0, 8'd0, 8'd0, 8'd0));
      send_item(make_req(lcsp_pkg::OP_BEAT, 9'd0, 8'd0, 8'd0, 8'd0, 8'd5));
      send_item(make_req(lcsp_pkg::OP_STOP, 9'd0, 8'd0, 8'd0, 8'd0, 8'd0));
      send_item(make_req(lcsp_pkg::OP_RESET, 9'd0, 8'd0, 8'd0, 8'd0, 8'd0));
      send_item(make_req(lcsp_pkg::OP_WRITE, 9'd0, 8'hFF, 8'd0, 8'd0, 8'd0));
      send_item(make_req(lcsp_pkg::OP_WRITE, 9'd383, 8'hA5, 8'd0, 8'd0, 8'd0));
      send_item(make_req(lcsp_pkg::OP_WRITE, 9'd511, 8'h00, 8'd0, 8'd0, 8'd0));
      send_item(make_req(lcsp_pkg::OP_WRITE, 9'd384, 8'h5A, 8'd0, 8'd0, 8'd0));
      send_item(make_req(OP_SPARE, 9'd511, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      // rejected commits
      send_item(make_req(lcsp_pkg::OP_COMMIT, 9'd0, 8'd0, 8'd0, 8'd1, 8'd0));
      send_item(make_req(lcsp_pkg::OP_COMMIT, 9'd0, 8'd0, 8'd1, 8'd0, 8'd0));
      send_item(make_req(lcsp_pkg::OP_COMMIT, 9'd0, 8'd0, 8'd255, 8'd17, 8'd0));
      send_item(make_req(lcsp_pkg::OP_COMMIT, 9'd0, 8'd0, 8'd1, 8'd255, 8'd0));
      // full pattern, one step per tick, last square then wrap
      send_item(make_req(lcsp_pkg::OP_COMMIT, 9'd0, 8'd0, 8'd1, 8'd16, 8'd0));
      send_item(make_req(lcsp_pkg::OP_TICK, 9'd0, 8'd0, 8'd0, 8'd0, 8'd0));
      send_item(make_req(lcsp_pkg::OP_TICK, 9'd0, 8'd0, 8'd0, 8'd0, 8'd0));
      send_item(make_req(lcsp_pkg::OP_BEAT, 9'd0, 8'd0, 8'd0, 8'd0, 8'd255));
      send_item(make_req(lcsp_pkg::OP_TICK, 9'd0, 8'd0, 8'd0, 8'd0, 8'd0));
      send_item(make_req(lcsp_pkg::OP_TICK, 9'd0, 8'd0, 8'd0, 8'd0, 8'd0));
      // single row, two ticks per step
      send_item(make_req(lcsp_pkg::OP_COMMIT, 9'd0, 8'd0, 8'd2, 8'd1, 8'd0));
      send_item(make_req(lcsp_pkg::OP_BEAT, 9'd0, 8'd0, 8'd0, 8'd0, 8'd16));
      send_item(make_req(lcsp_pkg::OP_TICK, 9'd0, 8'd0, 8'd0, 8'd0, 8'd0));
      send_item(make_req(lcsp_pkg::OP_RESET, 9'd0, 8'd0, 8'd0, 8'd0, 8'd0));
      send_item(make_req(lcsp_pkg::OP_START, 9'd0, 8'd0, 8'd0, 8'd0, 8'd0));
      send_item(make_req(lcsp_pkg::OP_STOP, 9'd0, 8'd0, 8'd0, 8'd0, 8'd0));

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         steady = (n >= 300 && n < 550);
         if (n == 700)
            drain();
         send_item(random_req());
      end
      steady = 1'b0;
      drain();
      repeat (8) @(negedge clock);

      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
